// ===== design/pitm_pkg.sv =====
package pitm_pkg;

    localparam int NODE_DEPTH  = 1024;
    localparam int TETRA_DEPTH = 1024;
    localparam int COORD_BITS  = 16;
    localparam int NODE_AW     = $clog2(NODE_DEPTH);
    localparam int TETRA_AW    = $clog2(TETRA_DEPTH);
    localparam int CORNER_BITS = 11;
    localparam int COUNT_BITS  = 11;
    localparam int SLOT_BITS   = 10;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int MINOR_BITS  = PROD_BITS + 1;
    localparam int TERM_BITS   = MINOR_BITS + DIFF_BITS;
    localparam int DET_BITS    = TERM_BITS + 2;

    typedef enum logic [1:0] {
        CMD_NODE  = 2'd0,
        CMD_TETRA = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TET_RD,
        ST_TET_WAIT,
        ST_CHECK,
        ST_NODE_RD,
        ST_NODE_WAIT,
        ST_SETUP,
        ST_MUL,
        ST_NEXT,
        ST_DONE
    } state_t;

endpackage

// ===== design/point_in_tetra_mesh_test.sv =====
// channel | ports                                        | dir
// s_      | command slot coord_x/y/z corner_a..corner_d  | in
// m_      | outside                                      | out
// cfg     | cfg_we cfg_data (tet_count)                  | in
// Node and tetra writes may follow back to back.
// m_valid rises after a query is accepted and its walk ends. Each tetra walked takes a tetra
// read, a node read per corner, 5 orientations (setup plus 10 steps on one shared
// 17x35 multiplier), then an advance. A bad corner or a failed sign ends a tetra early.
// Synchronous active-low reset clears control; the stores are not cleared.
// s_ready is low while a query walks or its result waits on m_ready.
module point_in_tetra_mesh_test
    import pitm_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [COUNT_BITS-1:0]         cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [SLOT_BITS-1:0]          s_slot,
    input  logic signed [COORD_BITS-1:0]  s_coord_x,
    input  logic signed [COORD_BITS-1:0]  s_coord_y,
    input  logic signed [COORD_BITS-1:0]  s_coord_z,
    input  logic [CORNER_BITS-1:0]        s_corner_a,
    input  logic [CORNER_BITS-1:0]        s_corner_b,
    input  logic [CORNER_BITS-1:0]        s_corner_c,
    input  logic [CORNER_BITS-1:0]        s_corner_d,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_outside
);

    logic [3*COORD_BITS-1:0]  node_mem [NODE_DEPTH];
    logic [4*CORNER_BITS-1:0] tet_mem  [TETRA_DEPTH];
    logic [3*COORD_BITS-1:0]  node_rd_reg;
    logic [4*CORNER_BITS-1:0] tet_rd_reg;
    logic [NODE_AW-1:0]       node_addr;
    logic [TETRA_AW-1:0]      tet_addr;

    state_t state_reg, state_next;
    logic [COUNT_BITS-1:0] tet_count_reg;
    logic [COUNT_BITS-1:0] walk_reg, walk_next;
    logic [COUNT_BITS-1:0] limit;
    logic [1:0] corner_reg, corner_next;
    logic [2:0] orient_reg, orient_next;
    logic [3:0] step_reg, step_next;
    logic hit_reg, hit_next, mvalid_reg, mvalid_next;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;
    logic signed [COORD_BITS-1:0] cx_reg [4];
    logic signed [COORD_BITS-1:0] cy_reg [4];
    logic signed [COORD_BITS-1:0] cz_reg [4];
    logic signed [DIFF_BITS-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [DIFF_BITS-1:0] ex_reg, ey_reg, ez_reg;
    logic signed [MINOR_BITS-1:0] minor_reg;
    logic signed [DET_BITS-1:0] acc_reg;
    logic signed [1:0] v0_reg;
    logic ok_reg;
    logic signed [COORD_BITS-1:0] px [4];
    logic signed [COORD_BITS-1:0] py [4];
    logic signed [COORD_BITS-1:0] pz [4];
    logic signed [DIFF_BITS-1:0] mul_a;
    logic signed [MINOR_BITS-1:0] mul_b;
    logic signed [TERM_BITS-1:0] prod;
    logic signed [1:0] sgn;
    logic sign_fail;
    logic tet_hit;
    logic [CORNER_BITS-1:0] cn;
    logic cn_bad;
    logic in_acc;

    assign limit  = (tet_count_reg > COUNT_BITS'(TETRA_DEPTH)) ?
                    COUNT_BITS'(TETRA_DEPTH) : tet_count_reg;
    assign in_acc = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE) && !mvalid_reg;
    assign m_valid   = mvalid_reg;
    assign m_outside = !hit_reg;

    assign cn = tet_rd_reg[corner_reg*CORNER_BITS +: CORNER_BITS];
    assign cn_bad = (cn == '0) || (cn > CORNER_BITS'(NODE_DEPTH));
    assign node_addr = NODE_AW'(cn - CORNER_BITS'(1));
    assign tet_addr  = walk_reg[TETRA_AW-1:0];

    always_ff @(posedge aclk) begin
        if (in_acc && cmd_t'(s_command) == CMD_NODE && {1'b0, s_slot} < 11'(NODE_DEPTH)) begin
            node_mem[s_slot[NODE_AW-1:0]] <= {s_coord_z, s_coord_y, s_coord_x};
        end
        if (in_acc && cmd_t'(s_command) == CMD_TETRA && {1'b0, s_slot} < 11'(TETRA_DEPTH)) begin
            tet_mem[s_slot[TETRA_AW-1:0]] <= {s_corner_d, s_corner_c, s_corner_b, s_corner_a};
        end
        node_rd_reg <= node_mem[node_addr];
        tet_rd_reg  <= tet_mem[tet_addr];
    end

    // orientation k replaces corner k-1 by the query point
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (orient_reg == 3'(i + 1)) begin
                px[i] = qx_reg; py[i] = qy_reg; pz[i] = qz_reg;
            end else begin
                px[i] = cx_reg[i]; py[i] = cy_reg[i]; pz[i] = cz_reg[i];
            end
        end
    end

    always_comb begin
        case (step_reg)
            4'd0: begin mul_a = bx_reg; mul_b = MINOR_BITS'(ey_reg); end
            4'd1: begin mul_a = by_reg; mul_b = MINOR_BITS'(ex_reg); end
            4'd2: begin mul_a = az_reg; mul_b = minor_reg; end
            4'd3: begin mul_a = bz_reg; mul_b = MINOR_BITS'(ex_reg); end
            4'd4: begin mul_a = bx_reg; mul_b = MINOR_BITS'(ez_reg); end
            4'd5: begin mul_a = ay_reg; mul_b = minor_reg; end
            4'd6: begin mul_a = by_reg; mul_b = MINOR_BITS'(ez_reg); end
            4'd7: begin mul_a = bz_reg; mul_b = MINOR_BITS'(ey_reg); end
            default: begin mul_a = ax_reg; mul_b = minor_reg; end
        endcase
        prod = TERM_BITS'(mul_a * mul_b);
    end

    assign sgn = (acc_reg > 0) ? 2'sd1 : ((acc_reg < 0) ? -2'sd1 : 2'sd0);
    assign sign_fail = (orient_reg == 3'd0) ? (sgn == 2'sd0) :
                       (sgn != 2'sd0 && sgn != v0_reg);
    assign tet_hit = ok_reg && orient_reg == 3'd5;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_acc && cmd_t'(s_command) == CMD_QUERY)
                              state_next = (limit == '0) ? ST_DONE : ST_TET_RD;
            ST_TET_RD:    state_next = ST_TET_WAIT;
            ST_TET_WAIT:  state_next = ST_CHECK;
            ST_CHECK:     state_next = cn_bad ? ST_NEXT : ST_NODE_RD;
            ST_NODE_RD:   state_next = ST_NODE_WAIT;
            ST_NODE_WAIT: state_next = (corner_reg == 2'd3) ? ST_SETUP : ST_CHECK;
            ST_SETUP:     state_next = ST_MUL;
            ST_MUL: begin
                if (step_reg == 4'd9) begin
                    if (!ok_reg || sign_fail) state_next = ST_NEXT;
                    else if (orient_reg == 3'd4) state_next = ST_NEXT;
                    else state_next = ST_SETUP;
                end
            end
            ST_NEXT:      state_next = (tet_hit || walk_reg + 1'b1 >= limit) ?
                                       ST_DONE : ST_TET_RD;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        walk_next = walk_reg;
        corner_next = corner_reg;
        orient_next = orient_reg;
        step_next = step_reg;
        hit_next = hit_reg;
        mvalid_next = mvalid_reg;
        if (mvalid_reg && m_ready) mvalid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    walk_next = '0;
                    hit_next = 1'b0;
                end
            end
            ST_TET_RD:   corner_next = 2'd0;
            ST_CHECK:    ;
            ST_NODE_WAIT: corner_next = corner_reg + 2'd1;
            ST_SETUP: begin
                step_next = 4'd0;
                if (corner_reg == 2'd0 && orient_reg == 3'd7) orient_next = 3'd0;
            end
            ST_MUL: begin
                if (step_reg == 4'd9) begin
                    step_next = 4'd0;
                    orient_next = orient_reg + 3'd1;
                end else step_next = step_reg + 4'd1;
            end
            ST_NEXT: begin
                if (tet_hit) hit_next = 1'b1;
                walk_next = walk_reg + 1'b1;
            end
            ST_DONE:     mvalid_next = 1'b1;
            default: ;
        endcase
        if (state_reg == ST_NODE_WAIT && corner_reg == 2'd3) orient_next = 3'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tet_count_reg <= '0;
            walk_reg <= '0;
            corner_reg <= '0;
            orient_reg <= '0;
            step_reg <= '0;
            hit_reg <= 1'b0;
            mvalid_reg <= 1'b0;
            ok_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            walk_reg <= walk_next;
            corner_reg <= corner_next;
            orient_reg <= orient_next;
            step_reg <= step_next;
            hit_reg <= hit_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we) tet_count_reg <= cfg_data;
            if (state_reg == ST_TET_RD) ok_reg <= 1'b1;
            if (state_reg == ST_CHECK && cn_bad) ok_reg <= 1'b0;
            if (state_reg == ST_MUL && step_reg == 4'd9 && sign_fail) ok_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            qx_reg <= s_coord_x;
            qy_reg <= s_coord_y;
            qz_reg <= s_coord_z;
        end
        if (state_reg == ST_NODE_WAIT) begin
            cx_reg[corner_reg] <= node_rd_reg[COORD_BITS-1:0];
            cy_reg[corner_reg] <= node_rd_reg[2*COORD_BITS-1:COORD_BITS];
            cz_reg[corner_reg] <= node_rd_reg[3*COORD_BITS-1:2*COORD_BITS];
        end
        if (state_reg == ST_SETUP) begin
            ax_reg <= DIFF_BITS'(px[0]) - DIFF_BITS'(px[3]);
            ay_reg <= DIFF_BITS'(py[0]) - DIFF_BITS'(py[3]);
            az_reg <= DIFF_BITS'(pz[0]) - DIFF_BITS'(pz[3]);
            bx_reg <= DIFF_BITS'(px[1]) - DIFF_BITS'(px[3]);
            by_reg <= DIFF_BITS'(py[1]) - DIFF_BITS'(py[3]);
            bz_reg <= DIFF_BITS'(pz[1]) - DIFF_BITS'(pz[3]);
            ex_reg <= DIFF_BITS'(px[2]) - DIFF_BITS'(px[3]);
            ey_reg <= DIFF_BITS'(py[2]) - DIFF_BITS'(py[3]);
            ez_reg <= DIFF_BITS'(pz[2]) - DIFF_BITS'(pz[3]);
            acc_reg <= '0;
        end
        // minor, minor, fold row term; three rows, then sign
        if (state_reg == ST_MUL) begin
            case (step_reg)
                4'd0, 4'd3, 4'd6: minor_reg <= MINOR_BITS'(prod);
                4'd1, 4'd4, 4'd7: minor_reg <= minor_reg - MINOR_BITS'(prod);
                4'd2, 4'd5, 4'd8: acc_reg <= acc_reg + DET_BITS'(prod);
                default: ;
            endcase
            if (step_reg == 4'd9 && orient_reg == 3'd0) v0_reg <= sgn;
        end
    end

endmodule
